@@ sv/binomial_pascal_dp_assert.svh @@
// binomial_pascal_dp_assert.svh: assertion macros shared by the RTL.
// Depends on clk and rst_n existing in the including module.
`ifndef BINOMIAL_PASCAL_DP_ASSERT_SVH
`define BINOMIAL_PASCAL_DP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BPD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define BPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/bpd_pkg.sv @@
// bpd_pkg.sv: constants and types for the binomial coefficient block.
// No dependencies.
`default_nettype none
package bpd_pkg;

    localparam int MAX_M     = 64;
    localparam int NUM_CELLS = MAX_M + 1;
    localparam int COEF_W    = 61;
    localparam int FIELD_W   = 7;

    typedef logic [COEF_W-1:0]  coef_t;
    typedef logic [FIELD_W-1:0] field_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic load;         // initialize: cell 0 to one, the rest to zero
        logic step;         // advance one row of the triangle
        logic toward_right; // add the right neighbor (row step plus shift)
    } bpd_ctl_t;

endpackage
`default_nettype wire

@@ sv/bpd_cell.sv @@
// bpd_cell.sv: one cell of the Pascal chain, holds one coefficient.
// Depends on bpd_pkg.
`default_nettype none
module bpd_cell
    import bpd_pkg::*;
(
    input  wire logic      clk,
    input  wire bpd_ctl_t  ctl,
    input  wire logic      init_one,
    input  wire coef_t     left_val,
    input  wire coef_t     right_val,
    output coef_t          val
);

    coef_t value_reg;
    coef_t value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load)
        begin
            value_next = init_one ? coef_t'(1) : '0;
        end
        else if (ctl.step)
        begin
            // sum wraps at the coefficient width
            value_next = value_reg + (ctl.toward_right ? right_val : left_val);
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign val = value_reg;

endmodule
`default_nettype wire

@@ sv/bpd_chain.sv @@
// bpd_chain.sv: row of NUM_CELLS cells, each fed by its neighbors (zero beyond either end).
// Depends on bpd_pkg and bpd_cell.
`default_nettype none
module bpd_chain
    import bpd_pkg::*;
(
    input  wire logic      clk,
    input  wire bpd_ctl_t  ctl,
    output coef_t          head
);

    coef_t cell_val [NUM_CELLS];

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        coef_t left_in;
        coef_t right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_inner_l
            assign left_in = cell_val[i-1];
        end

        if (i == NUM_CELLS - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_inner_r
            assign right_in = cell_val[i+1];
        end

        bpd_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .init_one  (i == 0),
            .left_val  (left_in),
            .right_val (right_in),
            .val       (cell_val[i])
        );
    end

    assign head = cell_val[0];

endmodule
`default_nettype wire

@@ sv/binomial_pascal_dp.sv @@
// binomial_pascal_dp: C(m,n) by Pascal's rule on a chain of 65 cells.
// Each input transfer loads the chain, then m_eff triangle row steps run (m_eff = min(m,64)),
// none when n > m, and the result is registered once the output side is free.
// No new input is taken while a run is in progress; the next input is taken while a
// result waits. Reset (rst_n, async, active low) clears sequencer and output valid;
// cells are reloaded at every input transfer, so their contents need no reset.
`default_nettype none
`include "binomial_pascal_dp_assert.svh"
module binomial_pascal_dp
    import bpd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire field_t set_size,
    input  wire field_t pick_count,
    output logic        out_valid,
    input  wire logic   out_stall,
    output coef_t       coefficient
);

    // Scheme: cell k holds C(r, k+s), s = shift so far. First (m-n) plain row
    // steps (add left neighbor), then n steps that also shift down by one
    // (add right neighbor). After m steps cell 0 holds C(m, n).

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic      state_reg,     state_next;
    field_t    steps_reg,     steps_next;   // row steps left
    field_t    build_reg,     build_next;   // plain (unshifted) steps left
    logic      zero_reg,      zero_next;    // n exceeds m
    logic      out_valid_reg, out_valid_next;
    coef_t     coefficient_reg, coefficient_next;

    bpd_ctl_t  ctl;
    coef_t     head;
    field_t    m_eff;
    logic      in_xfer;
    logic      out_free;
    logic      finish;

    bpd_chain u_chain (
        .clk  (clk),
        .ctl  (ctl),
        .head (head)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign m_eff    = (set_size > FIELD_W'(MAX_M)) ? FIELD_W'(MAX_M) : set_size;
    assign finish   = (state_reg == ST_RUN) && (steps_reg == '0) && out_free;

    always_comb
    begin
        state_next       = state_reg;
        steps_next       = steps_reg;
        build_next       = build_reg;
        zero_next        = zero_reg;
        out_valid_next   = out_valid_reg && out_stall;
        coefficient_next = coefficient_reg;
        ctl              = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    ctl.load   = 1'b1;
                    zero_next  = (pick_count > m_eff);
                    // nothing to build when the answer is zero anyway
                    steps_next = zero_next ? '0 : m_eff;
                    build_next = m_eff - pick_count;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (steps_reg != '0)
                begin
                    ctl.step         = 1'b1;
                    ctl.toward_right = (build_reg == '0);
                    steps_next       = steps_reg - 1'b1;
                    if (build_reg != '0)
                    begin
                        build_next = build_reg - 1'b1;
                    end
                end
                else if (finish)
                begin
                    out_valid_next   = 1'b1;
                    coefficient_next = zero_reg ? '0 : head;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            steps_reg     <= '0;
            build_reg     <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            build_reg     <= build_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, held while stalled
    always_ff @(posedge clk)
    begin
        coefficient_reg <= coefficient_next;
    end

    assign out_valid   = out_valid_reg;
    assign coefficient = coefficient_reg;

    // an input transfer always starts a run
    `BPD_ASSERT_NEXT(a_xfer_runs, in_xfer, state_reg == ST_RUN)
    // chain only loads on an input transfer
    `BPD_ASSERT_IMPL(a_load_on_xfer, ctl.load, in_xfer)
    // pending row steps always advance the chain
    `BPD_ASSERT_IMPL(a_step_pending, (state_reg == ST_RUN) && (steps_reg != '0), ctl.step)
    // plain steps left never outnumber remaining steps
    `BPD_ASSERT_IMPL(a_build_bound, (state_reg == ST_RUN) && !zero_reg, build_reg <= steps_reg)

endmodule
`default_nettype wire

@@ test/binomial_checker.sv @@
// binomial_checker.sv: watches both channels of binomial_pascal_dp, predicts C(m,n)
// for every input transfer and compares it with each result transfer.
// Depends on bpd_pkg (MAX_M, NUM_CELLS, coef_t, field_t).
module binomial_checker
    import bpd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   in_stall,
    input  field_t set_size,
    input  field_t pick_count,
    input  logic   out_valid,
    input  logic   out_stall,
    input  coef_t  coefficient,
    output int     error_count,
    output int     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    coef_t  coef_due[$];
    field_t rows_built;   // effective m of the last query
    int     shown;

    // m saturates at MAX_M; sums wrap at the coefficient width.
    function automatic coef_t pascal_coef(field_t m, field_t n);
        coef_t row [0:NUM_CELLS-1];
        int    top;
        top = (m > MAX_M) ? MAX_M : int'(m);
        for (int j = 0; j < NUM_CELLS; j++)
            row[j] = '0;
        row[0] = coef_t'(1);
        for (int r = 1; r <= top; r++)
            for (int j = r; j >= 1; j--)
                row[j] = row[j] + row[j-1];
        return (int'(n) > top) ? coef_t'(0) : row[n];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_due.delete();
            rows_built  = '0;
            error_count = 0;
            outstanding = 0;
            shown       = 0;
        end
        else
        begin
            // result first: it always belongs to an earlier input
            if (out_valid && !out_stall)
            begin
                if (coef_due.size() == 0)
                begin
                    error_count++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("%0t: unexpected result, coefficient %0d", $realtime,
                                 coefficient);
                    end
                end
                else
                begin
                    coef_t want;
                    want = coef_due.pop_front();
                    if (coefficient !== want)
                    begin
                        error_count++;
                        if (shown < 10)
                        begin
                            shown++;
                            $display("%0t: coefficient mismatch: expected %0d, got %0d",
                                     $realtime, want, coefficient);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                coef_due.push_back(pascal_coef(set_size, pick_count));
                rows_built = (set_size > MAX_M) ? field_t'(MAX_M) : set_size;
            end
            outstanding = coef_due.size();
        end
    end

endmodule

@@ test/tb.sv @@
// tb.sv: top of the binomial_pascal_dp testbench; drives query transfers, stalls the
// result channel at random and reports the verdict. Depends on bpd_pkg,
// binomial_pascal_dp and binomial_checker.
module tb;
    import bpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 650;
    localparam int MAX_WAIT     = 13;
    localparam int IDLE_LIMIT   = 2000;  // watchdog bound, covers the worst item plus end drain
    localparam int DRAIN_CYCLES = 80;    // wait after the final drain, longer than the longest item

    logic   clk        = 1'b0;
    logic   rst_n      = 1'b0;
    logic   in_valid   = 1'b0;
    field_t set_size   = '0;
    field_t pick_count = '0;
    logic   out_stall  = 1'b0;
    logic   in_stall;
    logic   out_valid;
    coef_t  coefficient;

    int     error_count;
    int     outstanding;
    bit     no_idle = 1'b0;   // stretches with no gaps and no stalls
    bit     out_taken = 1'b0;
    int     stall_left = 0;
    int     idle_cycles = 0;

    binomial_pascal_dp DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .set_size    (set_size),
        .pick_count  (pick_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coefficient (coefficient)
    );

    binomial_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .set_size    (set_size),
        .pick_count  (pick_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coefficient (coefficient),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // Result side: a fresh stall length is drawn after every result transfer.
    always @(posedge clk)
        out_taken <= rst_n && out_valid && !out_stall;

    always @(negedge clk)
    begin
        if (out_taken)
            stall_left = draw_wait();
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Entered and left at a falling edge. valid stays high into the next
    // query when no gap is drawn, so it is never lowered and raised in one step.
    task automatic send_query(int m, int n);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        set_size   <= field_t'(m);
        pick_count <= field_t'(n);
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Hold off input until every predicted coefficient has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int m;
        int n;
        int pick;

        stall_left = draw_wait();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty set, nothing chosen, too many chosen, saturation of m,
        // the widest coefficients and all-ones fields.
        send_query(0, 0);
        send_query(0, 1);
        send_query(0, 127);
        send_query(0, 64);
        send_query(1, 0);
        send_query(1, 1);
        send_query(1, 2);
        send_query(2, 1);
        send_query(5, 3);
        send_query(63, 31);
        send_query(64, 0);
        send_query(64, 32);
        send_query(64, 31);
        send_query(64, 64);
        send_query(64, 65);
        send_query(64, 127);
        send_query(65, 33);
        send_query(100, 50);
        send_query(127, 0);
        send_query(127, 32);
        send_query(127, 64);
        send_query(127, 65);
        send_query(127, 127);
        send_query(10, 127);

        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i % 150) >= 120;
            if (i == 330)
                drain_results();
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3, 4:
                begin
                    m = $urandom_range(0, MAX_M);
                    n = $urandom_range(0, m);
                end
                5:
                begin
                    m = $urandom_range(0, 127);
                    n = $urandom_range(0, 127);
                end
                6:
                begin
                    m = $urandom_range(MAX_M + 1, 127);
                    n = $urandom_range(0, MAX_M + 1);
                end
                7:
                begin
                    m = $urandom_range(0, MAX_M);
                    n = $urandom_range(m + 1, 127);
                end
                8:
                begin
                    m = $urandom_range(0, 8);
                    n = $urandom_range(0, 9);
                end
                default:
                begin
                    m = $urandom_range(0, 127);
                    n = $urandom_range(0, 1) ? 0 : m;
                end
            endcase
            send_query(m, n);
        end

        no_idle = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
